FILE: rtl/smeu_pkg.sv
package smeu_pkg;

    localparam int OP_BITS  = 5;
    localparam int IP_BITS  = 32;
    localparam int IMM_BITS = 32;
    localparam int OUT_BITS = 32;

    localparam logic [4:0] OP_PUSH    = 5'd0;
    localparam logic [4:0] OP_POP     = 5'd1;
    localparam logic [4:0] OP_ADD     = 5'd2;
    localparam logic [4:0] OP_SUB     = 5'd3;
    localparam logic [4:0] OP_MUL     = 5'd4;
    localparam logic [4:0] OP_DIV     = 5'd5;
    localparam logic [4:0] OP_MOD     = 5'd6;
    localparam logic [4:0] OP_INC     = 5'd7;
    localparam logic [4:0] OP_DEC     = 5'd8;
    localparam logic [4:0] OP_JGE     = 5'd9;
    localparam logic [4:0] OP_JGT     = 5'd10;
    localparam logic [4:0] OP_JLE     = 5'd11;
    localparam logic [4:0] OP_JLT     = 5'd12;
    localparam logic [4:0] OP_JEQ     = 5'd13;
    localparam logic [4:0] OP_JMP     = 5'd14;
    localparam logic [4:0] OP_OUT     = 5'd15;
    localparam logic [4:0] OP_DBG     = 5'd16;
    localparam logic [4:0] OP_STORE   = 5'd17;
    localparam logic [4:0] OP_LOAD    = 5'd18;
    localparam logic [4:0] OP_SSTORE  = 5'd19;
    localparam logic [4:0] OP_SLOAD   = 5'd20;
    localparam logic [4:0] OP_HALT    = 5'd21;
    localparam logic [4:0] OP_RESTART = 5'd22;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_DIV_ZERO  = 3'd3;
    localparam logic [2:0] ERR_ADDRESS   = 3'd4;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_OUT  = 2'd1;
    localparam logic [1:0] KIND_DBG  = 2'd2;

    typedef logic [OP_BITS-1:0]  op_t;
    typedef logic [IP_BITS-1:0]  ip_t;
    typedef logic [IMM_BITS-1:0] imm_t;
    typedef logic [OUT_BITS-1:0] out_word_t;
    typedef logic [2:0]          err_t;
    typedef logic [1:0]          kind_t;
    typedef logic [3:0]          bmask_t;

endpackage

FILE: rtl/stack_machine_execute_unit.sv
// Channel | Handshake             | Payload
// in      | in_valid / in_stall   | op, operand_a, operand_b
// out     | out_valid / out_stall | next_ip, halted, out_kind, out_word,
//         |                       | out_byte_mask, error
// For most opcodes an item passes through these steps between input transfers: accept,
// two stack reads, execute and result; div and mod add the iterations of the shared restoring
// divider and a write-back, mul the iterations of the shift-add unit (which shares its
// registers with the divider) and a write-back, load and sload a memory read and a write-back.
// After reset, and after restart, a clearing pass writes zero to MEM_DEPTH memory words,
// one per cycle; no item is taken during it.
// Output is registered; in_stall stays high until the result has been transferred.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int MEM_DEPTH   = 1024,
    parameter int WORD_BITS   = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  smeu_pkg::op_t             op,
    input  smeu_pkg::imm_t            operand_a,
    input  smeu_pkg::imm_t            operand_b,
    output logic                      out_valid,
    input  logic                      out_stall,
    output smeu_pkg::ip_t             next_ip,
    output logic                      halted,
    output smeu_pkg::kind_t           out_kind,
    output smeu_pkg::out_word_t       out_word,
    output smeu_pkg::bmask_t          out_byte_mask,
    output smeu_pkg::err_t            error
);
    import smeu_pkg::*;

    localparam int SP_BITS  = $clog2(STACK_DEPTH);
    localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
    localparam int MA_BITS  = $clog2(MEM_DEPTH);
    localparam int IT_BITS  = $clog2(WORD_BITS + 1);
    localparam int OB       = (WORD_BITS < OUT_BITS) ? WORD_BITS : OUT_BITS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MEMRD = 4'd7;
    localparam logic [3:0] S_MEMWB = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_BITS-1:0] data_mem  [MEM_DEPTH];

    logic [3:0]           state_reg, state_next;
    ip_t                  ip_reg, ip_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 halt_reg, halt_next;
    logic [MA_BITS-1:0]   clr_reg, clr_next;
    op_t                  op_reg;
    imm_t                 a_reg, b_reg;
    logic [WORD_BITS-1:0] top_reg, sec_reg, rd_data_reg;
    logic [SP_BITS-1:0]   rd_addr;
    logic [WORD_BITS-1:0] acc_reg, acc_next, sh_reg, sh_next, q_reg, q_next;
    logic [IT_BITS-1:0]   it_reg, it_next;
    logic                 ov_reg, ov_next;
    ip_t                  nip_reg, nip_next;
    err_t                 err_reg, err_next;
    kind_t                kind_reg, kind_next;
    out_word_t            word_reg, word_next;
    bmask_t               bm_reg, bm_next;
    logic                 sw_en;
    logic [SP_BITS-1:0]   sw_addr;
    logic [WORD_BITS-1:0] sw_data;
    logic                 mw_en;
    logic [MA_BITS-1:0]   mw_addr;
    logic [WORD_BITS-1:0] mw_data;
    logic [MA_BITS-1:0]   mr_addr;
    logic [WORD_BITS-1:0] a_w;
    logic                 cond;
    logic [WORD_BITS:0]   dtrial;

    assign in_stall  = (state_reg != S_IDLE);
    assign a_w       = WORD_BITS'(a_reg);
    assign rd_addr   = (state_reg == S_RD1) ? SP_BITS'(cnt_reg - CNT_BITS'(1))
                                            : SP_BITS'(cnt_reg - CNT_BITS'(2));
    assign mr_addr   = (op_reg == OP_LOAD) ? MA_BITS'(a_reg) : MA_BITS'(top_reg);
    assign dtrial    = {acc_reg, sh_reg[WORD_BITS-1]} - {1'b0, sec_reg};

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            stack_mem[sw_addr] <= sw_data;
        end
        top_reg <= (state_reg == S_RD1) ? stack_mem[rd_addr] : top_reg;
        sec_reg <= (state_reg == S_RD2) ? stack_mem[rd_addr] : sec_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= op;
            a_reg  <= operand_a;
            b_reg  <= operand_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            data_mem[mw_addr] <= mw_data;
        end
        rd_data_reg <= data_mem[mr_addr];
    end

    always_comb
    begin
        case (op_reg)
            OP_JGE:  cond = top_reg >= a_w;
            OP_JGT:  cond = top_reg >  a_w;
            OP_JLE:  cond = top_reg <= a_w;
            OP_JLT:  cond = top_reg <  a_w;
            default: cond = top_reg == a_w;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ip_next    = ip_reg;
        cnt_next   = cnt_reg;
        halt_next  = halt_reg;
        clr_next   = clr_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        it_next    = it_reg;
        ov_next    = ov_reg;
        nip_next   = nip_reg;
        err_next   = err_reg;
        kind_next  = kind_reg;
        word_next  = word_reg;
        bm_next    = bm_reg;
        sw_en      = 1'b0;
        sw_addr    = SP_BITS'(cnt_reg - CNT_BITS'(1));
        sw_data    = acc_reg;
        mw_en      = 1'b0;
        mw_addr    = clr_reg;
        mw_data    = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mw_en    = 1'b1;
                clr_next = clr_reg + MA_BITS'(1);
                if (32'(clr_reg) == MEM_DEPTH - 1)
                begin
                    clr_next   = '0;
                    state_next = ov_reg ? S_DONE : S_IDLE;
                    ov_next    = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                state_next = S_RD2;
            end
            S_RD2:
            begin
                state_next = S_EXEC;
                err_next   = ERR_OK;
                kind_next  = KIND_NONE;
                word_next  = '0;
                bm_next    = '0;
                nip_next   = ip_reg + IP_BITS'(1);
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if (op_reg == OP_RESTART)
                begin
                    ip_next    = '0;
                    cnt_next   = '0;
                    halt_next  = 1'b0;
                    nip_next   = '0;
                    clr_next   = '0;
                    ov_next    = 1'b1;
                    state_next = S_CLEAR;
                end
                else if (halt_reg)
                begin
                    nip_next = ip_reg;
                end
                else
                begin
                    case (op_reg)
                        OP_PUSH:
                        begin
                            nip_next = ip_reg + IP_BITS'(2);
                            if (32'(cnt_reg) >= STACK_DEPTH) err_next = ERR_OVERFLOW;
                            else
                            begin
                                sw_en    = 1'b1;
                                sw_addr  = SP_BITS'(cnt_reg);
                                sw_data  = a_w;
                                cnt_next = cnt_reg + CNT_BITS'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (cnt_reg < CNT_BITS'(1)) err_next = ERR_UNDERFLOW;
                            else cnt_next = cnt_reg - CNT_BITS'(1);
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                        begin
                            if (cnt_reg < CNT_BITS'(2)) err_next = ERR_UNDERFLOW;
                            else if ((op_reg == OP_DIV || op_reg == OP_MOD) && sec_reg == '0)
                                err_next = ERR_DIV_ZERO;
                            else if (op_reg == OP_ADD || op_reg == OP_SUB)
                            begin
                                sw_en    = 1'b1;
                                sw_addr  = SP_BITS'(cnt_reg - CNT_BITS'(2));
                                sw_data  = (op_reg == OP_ADD) ? top_reg + sec_reg
                                                              : top_reg - sec_reg;
                                cnt_next = cnt_reg - CNT_BITS'(1);
                            end
                            else
                            begin
                                acc_next   = '0;
                                sh_next    = top_reg;
                                q_next     = sec_reg;
                                it_next    = '0;
                                state_next = (op_reg == OP_MUL) ? S_MUL : S_DIV;
                            end
                        end
                        OP_INC, OP_DEC:
                        begin
                            if (cnt_reg < CNT_BITS'(1)) err_next = ERR_UNDERFLOW;
                            else
                            begin
                                sw_en   = 1'b1;
                                sw_data = (op_reg == OP_INC) ? top_reg + WORD_BITS'(1)
                                                             : top_reg - WORD_BITS'(1);
                            end
                        end
                        OP_JGE, OP_JGT, OP_JLE, OP_JLT, OP_JEQ:
                        begin
                            nip_next = ip_reg + IP_BITS'(3);
                            if (cnt_reg < CNT_BITS'(1)) err_next = ERR_UNDERFLOW;
                            else if (cond) nip_next = b_reg;
                        end
                        OP_JMP:
                        begin
                            nip_next = a_reg;
                        end
                        OP_OUT, OP_DBG:
                        begin
                            if (cnt_reg < CNT_BITS'(1)) err_next = ERR_UNDERFLOW;
                            else
                            begin
                                word_next = OUT_BITS'(top_reg[OB-1:0]);
                                if (op_reg == OP_OUT)
                                begin
                                    kind_next = KIND_OUT;
                                    for (int i = 0; i < 4; i++)
                                    begin
                                        bm_next[i] = (word_next[8*i +: 8] != 8'd0);
                                    end
                                end
                                else kind_next = KIND_DBG;
                            end
                        end
                        OP_STORE:
                        begin
                            nip_next = ip_reg + IP_BITS'(2);
                            if (cnt_reg < CNT_BITS'(1)) err_next = ERR_UNDERFLOW;
                            else if (64'(a_reg) >= 64'(MEM_DEPTH)) err_next = ERR_ADDRESS;
                            else
                            begin
                                mw_en    = 1'b1;
                                mw_addr  = MA_BITS'(a_reg);
                                mw_data  = top_reg;
                                cnt_next = cnt_reg - CNT_BITS'(1);
                            end
                        end
                        OP_LOAD:
                        begin
                            nip_next = ip_reg + IP_BITS'(2);
                            if (32'(cnt_reg) >= STACK_DEPTH) err_next = ERR_OVERFLOW;
                            else if (64'(a_reg) >= 64'(MEM_DEPTH)) err_next = ERR_ADDRESS;
                            else state_next = S_MEMRD;
                        end
                        OP_SSTORE:
                        begin
                            if (cnt_reg < CNT_BITS'(2)) err_next = ERR_UNDERFLOW;
                            else if (65'(top_reg) >= 65'(MEM_DEPTH)) err_next = ERR_ADDRESS;
                            else
                            begin
                                mw_en    = 1'b1;
                                mw_addr  = MA_BITS'(top_reg);
                                mw_data  = sec_reg;
                                cnt_next = cnt_reg - CNT_BITS'(1);
                            end
                        end
                        OP_SLOAD:
                        begin
                            if (cnt_reg < CNT_BITS'(1)) err_next = ERR_UNDERFLOW;
                            else if (65'(top_reg) >= 65'(MEM_DEPTH)) err_next = ERR_ADDRESS;
                            else state_next = S_MEMRD;
                        end
                        OP_HALT:
                        begin
                            halt_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                if (q_reg[0]) acc_next = acc_reg + sh_reg;
                sh_next = sh_reg << 1;
                q_next  = q_reg >> 1;
                it_next = it_reg + IT_BITS'(1);
                if (32'(it_reg) == WORD_BITS - 1)
                begin
                    state_next = S_MEMWB;
                    if (q_reg[0]) acc_next = acc_reg + sh_reg;
                end
            end
            S_DIV:
            begin
                sh_next = {sh_reg[WORD_BITS-2:0], ~dtrial[WORD_BITS]};
                if (!dtrial[WORD_BITS]) acc_next = dtrial[WORD_BITS-1:0];
                else acc_next = {acc_reg[WORD_BITS-2:0], sh_reg[WORD_BITS-1]};
                it_next = it_reg + IT_BITS'(1);
                if (32'(it_reg) == WORD_BITS - 1)
                begin
                    state_next = S_MEMWB;
                end
            end
            S_MEMRD:
            begin
                state_next = S_MEMWB;
            end
            S_MEMWB:
            begin
                state_next = S_DONE;
                sw_en      = 1'b1;
                case (op_reg)
                    OP_MUL:
                    begin
                        sw_addr  = SP_BITS'(cnt_reg - CNT_BITS'(2));
                        cnt_next = cnt_reg - CNT_BITS'(1);
                    end
                    OP_DIV:
                    begin
                        sw_addr  = SP_BITS'(cnt_reg - CNT_BITS'(2));
                        sw_data  = sh_reg;
                        cnt_next = cnt_reg - CNT_BITS'(1);
                    end
                    OP_MOD:
                    begin
                        sw_addr  = SP_BITS'(cnt_reg - CNT_BITS'(2));
                        cnt_next = cnt_reg - CNT_BITS'(1);
                    end
                    OP_LOAD:
                    begin
                        sw_addr  = SP_BITS'(cnt_reg);
                        sw_data  = rd_data_reg;
                        cnt_next = cnt_reg + CNT_BITS'(1);
                    end
                    default:
                    begin
                        sw_data = rd_data_reg;
                    end
                endcase
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_EXEC && op_reg != OP_RESTART && !halt_reg && err_next != ERR_OK)
        begin
            cnt_next   = cnt_reg;
            halt_next  = 1'b1;
            nip_next   = ip_reg;
            kind_next  = KIND_NONE;
            word_next  = '0;
            bm_next    = '0;
            sw_en      = 1'b0;
            mw_en      = 1'b0;
            state_next = S_DONE;
        end
        else if (state_reg == S_EXEC && op_reg != OP_RESTART)
        begin
            ip_next = nip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ip_reg    <= '0;
            cnt_reg   <= '0;
            halt_reg  <= 1'b0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ip_reg    <= ip_next;
            cnt_reg   <= cnt_next;
            halt_reg  <= halt_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        sh_reg   <= sh_next;
        q_reg    <= q_next;
        it_reg   <= it_next;
        nip_reg  <= nip_next;
        err_reg  <= err_next;
        kind_reg <= kind_next;
        word_reg <= word_next;
        bm_reg   <= bm_next;
    end

    assign out_valid     = (state_reg == S_DONE);
    assign next_ip       = nip_reg;
    assign halted        = halt_reg;
    assign out_kind      = kind_reg;
    assign out_word      = word_reg;
    assign out_byte_mask = bm_reg;
    assign error         = err_reg;

endmodule

FILE: rtl/smeu_checker.sv
module smeu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input smeu_pkg::ip_t       next_ip,
    input logic                halted,
    input smeu_pkg::kind_t     out_kind,
    input smeu_pkg::bmask_t    out_byte_mask,
    input smeu_pkg::err_t      error
);
    import smeu_pkg::*;

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error != ERR_OK |-> halted && out_kind == KIND_NONE)
        else $error("error result without halt");

    a_mask_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_OUT |-> out_byte_mask == 4'd0)
        else $error("byte mask outside OUT");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_ip) && $stable(error))
        else $error("stalled result changed");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .next_ip      (next_ip),
    .halted       (halted),
    .out_kind     (out_kind),
    .out_byte_mask(out_byte_mask),
    .error        (error)
);
